>>> rtl/rlbu_pkg.sv
// rlbu_pkg: blend mode codes, rounding constants and the per-channel blend function
// for the rgb layer blend unit.
// No dependencies.
package rlbu_pkg;

    // blend mode codes as held in the mode register
    typedef enum logic [1:0] {
        MODE_MULTIPLY = 2'd0,
        MODE_SUBTRACT = 2'd1,
        MODE_SCREEN   = 2'd2,
        MODE_OVERLAY  = 2'd3
    } blend_mode_t;

    localparam int unsigned CH_W = 8;

    // overlay picks the dark branch when the bottom channel sum is at most this
    localparam logic [9:0] OVL_SPLIT = 10'd382;

    localparam logic [15:0] FULL_SQ = 16'd65025;

    // numerators at or above this round to more than full scale
    localparam logic [16:0] SAT_HI = 17'd65153;

    // subtracted terms at or above this leave a numerator that rounds to zero
    localparam logic [16:0] SAT_LO = 17'd64898;

    // round x/255 to nearest, valid for x up to 65152
    function automatic logic [CH_W-1:0] div255_round(input logic [15:0] x);
        logic [16:0] t;
        logic [16:0] s;
        begin
            t = {1'b0, x} + 17'd128;
            s = t + {8'd0, t[16:8]};
            div255_round = s[15:8];
        end
    endfunction

    // one channel of the blend: a is the top value, b the bottom value
    function automatic logic [CH_W-1:0] blend_channel(
        input blend_mode_t     mode,
        input logic [CH_W-1:0] a,
        input logic [CH_W-1:0] b,
        input logic            dark
    );
        logic            inv;
        logic [CH_W-1:0] op_a;
        logic [CH_W-1:0] op_b;
        logic [15:0]     prod;
        logic [16:0]     term;
        logic [15:0]     num;
        logic [CH_W-1:0] res;
        begin
            // screen and light overlay work on the inverted channels
            inv  = (mode == MODE_SCREEN) || ((mode == MODE_OVERLAY) && !dark);
            op_a = inv ? ~a : a;
            op_b = inv ? ~b : b;
            prod = op_a * op_b;
            // overlay doubles the product
            term = (mode == MODE_OVERLAY) ? {prod, 1'b0} : {1'b0, prod};
            num  = FULL_SQ - term[15:0];
            case (mode)
                MODE_SUBTRACT:
                begin
                    res = (a > b) ? (a - b) : '0;
                end
                default:
                begin
                    if (!inv)
                    begin
                        res = (term >= SAT_HI) ? '1 : div255_round(term[15:0]);
                    end
                    else
                    begin
                        res = (term >= SAT_LO) ? '0 : div255_round(num);
                    end
                end
            endcase
            blend_channel = res;
        end
    endfunction

endpackage

>>> rtl/rgb_layer_blend_unit.sv
// rgb_layer_blend_unit: two-stage blend of a top and a bottom BGR pixel under a
// configured mode (multiply, subtract, screen, overlay). Depends on rlbu_pkg.
//
// One pixel pair is taken per clock while in_stall is low. The pair lands in the input
// register when accepted and the blended pixel is loaded from there into the result
// register, which drives the output. One 8x8 multiplier per channel and the divide-by-255
// rounding as shift-and-add sit between the two registers.
// Both stages hold their request under downstream stall, so a new pair is still taken
// while a finished result waits if the input register is empty. The mode register is
// written with cfg_write_en and must only change while no request is in flight.
module rgb_layer_blend_unit (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_write_en,
    input  logic [1:0] cfg_write_data,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] top_blue,
    input  logic [7:0] top_green,
    input  logic [7:0] top_red,
    input  logic [7:0] bottom_blue,
    input  logic [7:0] bottom_green,
    input  logic [7:0] bottom_red,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_blue,
    output logic [7:0] out_green,
    output logic [7:0] out_red
);
    import rlbu_pkg::*;

    blend_mode_t     mode_reg;
    logic            s1_valid_reg;
    logic [CH_W-1:0] top_b_reg, top_g_reg, top_r_reg;
    logic [CH_W-1:0] bot_b_reg, bot_g_reg, bot_r_reg;
    logic            out_valid_reg;
    logic [CH_W-1:0] out_b_reg, out_g_reg, out_r_reg;
    logic [CH_W-1:0] out_b_next, out_g_next, out_r_next;
    logic            adv_out;
    logic            adv_in;
    logic            in_take;
    logic [9:0]      bot_sum;
    logic            dark;

    // stage advance: each stage moves when the one after it has room
    assign adv_out  = !out_valid_reg || !out_stall;
    assign adv_in   = !s1_valid_reg || adv_out;
    assign in_stall = !adv_in;
    assign in_take  = in_valid && adv_in;

    // mode register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_MULTIPLY;
        end
        else if (cfg_write_en)
        begin
            mode_reg <= blend_mode_t'(cfg_write_data);
        end
    end

    // input register stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (adv_in)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            top_b_reg <= top_blue;
            top_g_reg <= top_green;
            top_r_reg <= top_red;
            bot_b_reg <= bottom_blue;
            bot_g_reg <= bottom_green;
            bot_r_reg <= bottom_red;
        end
    end

    // overlay branch select and per-channel blend
    always_comb
    begin
        bot_sum    = {2'b00, bot_b_reg} + {2'b00, bot_g_reg} + {2'b00, bot_r_reg};
        dark       = (bot_sum <= OVL_SPLIT);
        out_b_next = blend_channel(mode_reg, top_b_reg, bot_b_reg, dark);
        out_g_next = blend_channel(mode_reg, top_g_reg, bot_g_reg, dark);
        out_r_next = blend_channel(mode_reg, top_r_reg, bot_r_reg, dark);
    end

    // result register stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv_out)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv_out && s1_valid_reg)
        begin
            out_b_reg <= out_b_next;
            out_g_reg <= out_g_next;
            out_r_reg <= out_r_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_blue  = out_b_reg;
    assign out_green = out_g_reg;
    assign out_red   = out_r_reg;

    // an accepted request always lands in the input stage
    a_take_lands: assert property (@(posedge clk) disable iff (!rst_n)
        in_take |=> s1_valid_reg)
        else $error("accepted request did not reach the input stage");

    // a request blocked by the result stage is not dropped
    a_s1_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !adv_out) |=> s1_valid_reg)
        else $error("input stage lost a blocked request");

    // a request leaving the input stage reaches the result register
    a_s1_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && adv_out) |=> out_valid_reg)
        else $error("request lost between stages");

    // upstream is only stalled when both stages are occupied
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid_reg && out_valid_reg))
        else $error("stall raised with room in the pipeline");

endmodule

>>> dv/blend_check_pkg.sv
// blend_check_pkg: pixel type and scoreboard for the rgb layer blend unit testbench.
// The scoreboard predicts each blended pixel and checks the block's results in order.
// Depends on rlbu_pkg for the blend mode codes.
`timescale 1ns / 1ps

package blend_check_pkg;

    import rlbu_pkg::*;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } pixel_t;

    localparam int FULL_SCALE  = 255;
    localparam int FULL_SQUARE = 65025;
    localparam int DARK_LIMIT  = 382;

    class blend_scoreboard;

        blend_mode_t mode;
        pixel_t      expected_pixels[$];
        int unsigned errors;

        function new();
            mode   = MODE_MULTIPLY;
            errors = 0;
        endfunction

        function void set_mode(blend_mode_t m);
            mode = m;
        endfunction

        function int pending();
            return expected_pixels.size();
        endfunction

        // nearest integer of n/255, clamped to a byte
        static function logic [7:0] round_to_byte(longint n);
            longint num;
            num = 2 * n + FULL_SCALE;
            if (num <= 0)
                return 8'd0;
            num = num / (2 * FULL_SCALE);
            if (num > FULL_SCALE)
                num = FULL_SCALE;
            return num[7:0];
        endfunction

        // one channel: a from the top layer, b from the bottom layer
        static function logic [7:0] blend_value(blend_mode_t m, int a, int b, bit dark);
            case (m)
                MODE_MULTIPLY:
                begin
                    return round_to_byte(a * b);
                end
                MODE_SUBTRACT:
                begin
                    return (a > b) ? 8'(a - b) : 8'd0;
                end
                MODE_SCREEN:
                begin
                    return round_to_byte(FULL_SQUARE - (FULL_SCALE - a) * (FULL_SCALE - b));
                end
                default:
                begin
                    if (dark)
                        return round_to_byte(2 * a * b);
                    return round_to_byte(FULL_SQUARE - 2 * (FULL_SCALE - a) * (FULL_SCALE - b));
                end
            endcase
        endfunction

        function pixel_t blend_pixel(pixel_t top, pixel_t bottom);
            int     bottom_sum;
            bit     dark;
            pixel_t res;
            bottom_sum = bottom.blue;
            bottom_sum += bottom.green;
            bottom_sum += bottom.red;
            // overlay branch is chosen once per pixel from the bottom brightness
            dark      = (bottom_sum <= DARK_LIMIT);
            res.blue  = blend_value(mode, top.blue, bottom.blue, dark);
            res.green = blend_value(mode, top.green, bottom.green, dark);
            res.red   = blend_value(mode, top.red, bottom.red, dark);
            return res;
        endfunction

        function void note_request(pixel_t top, pixel_t bottom);
            expected_pixels.insert(expected_pixels.size(), blend_pixel(top, bottom));
        endfunction

        function void compare_channel(string name, logic [7:0] exp_v, logic [7:0] got_v);
            if (got_v !== exp_v)
            begin
                errors++;
                $display("%0t: %s mismatch, expected %0d, actual %0d",
                         $time, name, exp_v, got_v);
            end
        endfunction

        function void check_result(pixel_t got);
            pixel_t exp_p;
            if (expected_pixels.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result, expected none, actual %0d/%0d/%0d",
                         $time, got.blue, got.green, got.red);
                return;
            end
            exp_p = expected_pixels.pop_front();
            compare_channel("blue", exp_p.blue, got.blue);
            compare_channel("green", exp_p.green, got.green);
            compare_channel("red", exp_p.red, got.red);
        endfunction

    endclass

endpackage

>>> dv/tb_top.sv
// tb_top: drives pixel pairs and mode writes into rgb_layer_blend_unit under varied
// sender idling and receiver stalls, checking every blended pixel against the scoreboard.
// Depends on rlbu_pkg and blend_check_pkg.
`timescale 1ns / 1ps

module tb_top;

    import rlbu_pkg::*;
    import blend_check_pkg::*;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int HOLD_CYCLES    = 80;
    localparam int PHASE_ITEMS    = 54;
    localparam int NUM_PHASES     = 8;

    logic       clk            = 1'b0;
    logic       rst_n          = 1'b0;
    logic       cfg_write_en   = 1'b0;
    logic [1:0] cfg_write_data = MODE_MULTIPLY;
    logic       in_valid       = 1'b0;
    logic       in_stall;
    logic [7:0] top_blue       = '0;
    logic [7:0] top_green      = '0;
    logic [7:0] top_red        = '0;
    logic [7:0] bottom_blue    = '0;
    logic [7:0] bottom_green   = '0;
    logic [7:0] bottom_red     = '0;
    logic       out_valid;
    logic       out_stall      = 1'b0;
    logic [7:0] out_blue;
    logic [7:0] out_green;
    logic [7:0] out_red;

    blend_scoreboard sb = new();

    int send_idle_pct = 0;
    int stall_pct     = 0;
    bit hold_request  = 1'b0;
    int hold_left     = 0;
    int idle_cycles   = 0;

    int          phase_send_idle[4] = '{0, 58, 0, 22};
    int          phase_stall[4]     = '{0, 0, 58, 22};
    blend_mode_t phase_mode[NUM_PHASES] = '{MODE_MULTIPLY, MODE_SUBTRACT, MODE_SCREEN,
                                            MODE_OVERLAY, MODE_SUBTRACT, MODE_SCREEN,
                                            MODE_OVERLAY, MODE_MULTIPLY};

    rgb_layer_blend_unit u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .top_blue       (top_blue),
        .top_green      (top_green),
        .top_red        (top_red),
        .bottom_blue    (bottom_blue),
        .bottom_green   (bottom_green),
        .bottom_red     (bottom_red),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .out_blue       (out_blue),
        .out_green      (out_green),
        .out_red        (out_red)
    );

    // clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // receiver stall, with a long hold-off when requested
    always @(negedge clk)
    begin
        if (hold_request)
        begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
        end
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left--;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // result check
    always @(posedge clk)
    begin : sample_out
        pixel_t got;
        if (rst_n && out_valid && !out_stall)
        begin
            got.blue  = out_blue;
            got.green = out_green;
            got.red   = out_red;
            sb.check_result(got);
        end
    end

    // watchdog on cycles with no request moving on either side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    // channel values lean towards the ends of the range
    function automatic logic [7:0] rand_channel();
        case ($urandom_range(7))
            0:       return 8'd0;
            1:       return 8'd255;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    function automatic pixel_t rand_pixel();
        pixel_t p;
        p.blue  = rand_channel();
        p.green = rand_channel();
        p.red   = rand_channel();
        return p;
    endfunction

    // bottom pixel, often with a channel sum right at the overlay split
    function automatic pixel_t rand_bottom();
        pixel_t p;
        int     target;
        int     b;
        int     g;
        int     lo;
        int     hi;
        if ($urandom_range(3) != 0)
            return rand_pixel();
        target = 381 + $urandom_range(3);
        b      = $urandom_range(255);
        lo     = (target - b - 255 > 0) ? target - b - 255 : 0;
        hi     = (target - b < 255) ? target - b : 255;
        g      = $urandom_range(hi, lo);
        p.blue  = 8'(b);
        p.green = 8'(g);
        p.red   = 8'(target - b - g);
        return p;
    endfunction

    task automatic drive_payload(input pixel_t top, input pixel_t bottom);
        top_blue     <= top.blue;
        top_green    <= top.green;
        top_red      <= top.red;
        bottom_blue  <= bottom.blue;
        bottom_green <= bottom.green;
        bottom_red   <= bottom.red;
    endtask

    // one request; entered and left at a falling edge
    task automatic send_pixel(input pixel_t top, input pixel_t bottom);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            drive_payload(rand_pixel(), rand_pixel());
            @(negedge clk);
        end
        in_valid <= 1'b1;
        drive_payload(top, bottom);
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_request(top, bottom);
        @(negedge clk);
    endtask

    // lower valid and wait for every expected pixel; ends at a falling edge
    task automatic wait_idle();
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (sb.pending() != 0);
    endtask

    task automatic write_mode(input blend_mode_t m);
        cfg_write_en   <= 1'b1;
        cfg_write_data <= m;
        @(posedge clk);
        sb.set_mode(m);
        @(negedge clk);
        cfg_write_en   <= 1'b0;
    endtask

    // range ends and both sides of the overlay split
    task automatic directed_set();
        send_pixel('{8'd0, 8'd0, 8'd0}, '{8'd0, 8'd0, 8'd0});
        send_pixel('{8'd255, 8'd255, 8'd255}, '{8'd255, 8'd255, 8'd255});
        send_pixel('{8'd255, 8'd255, 8'd255}, '{8'd0, 8'd0, 8'd0});
        send_pixel('{8'd0, 8'd0, 8'd0}, '{8'd255, 8'd255, 8'd255});
        send_pixel('{8'd255, 8'd255, 8'd255}, '{8'd255, 8'd127, 8'd0});
        send_pixel('{8'd0, 8'd200, 8'd100}, '{8'd0, 8'd128, 8'd255});
    endtask

    // stimulus
    initial
    begin
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: first set under the reset mode, then each other mode
        directed_set();
        wait_idle();
        write_mode(MODE_SUBTRACT);
        directed_set();
        wait_idle();
        write_mode(MODE_SCREEN);
        directed_set();
        wait_idle();
        write_mode(MODE_OVERLAY);
        directed_set();

        // random phases over idling profiles and modes
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            wait_idle();
            @(posedge clk);
            send_idle_pct = phase_send_idle[p % 4];
            stall_pct     = phase_stall[p % 4];
            if (p == 4)
                hold_request = 1'b1;
            @(negedge clk);
            write_mode(phase_mode[p]);
            for (int i = 0; i < PHASE_ITEMS; i++)
                send_pixel(rand_pixel(), rand_bottom());
        end

        wait_idle();
        repeat (4) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
